// ----- rtl/core/itt_pkg.sv -----
`timescale 1ns / 1ps

package itt_pkg;

	localparam int SLOTS   = 16;
	localparam int MAX_OUT = 16;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W  = $clog2(SLOTS + 1);
	localparam int GEN_W   = 16;
	localparam int ID_W    = 20;
	localparam int FIRE_W  = $clog2(MAX_OUT + 1);

	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

	localparam logic [2:0] FN_ADD    = 3'd0;
	localparam logic [2:0] FN_STOP   = 3'd1;
	localparam logic [2:0] FN_CLEAR  = 3'd2;
	localparam logic [2:0] FN_TICK   = 3'd3;
	localparam logic [2:0] FN_RSTALL = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_IVL  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_LINK,
		S_CHECK,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0]      expiry;
		logic [23:0]      period;
		logic [GEN_W-1:0] gen;
		logic [7:0]       handler;
		logic [31:0]      arg;
	} rec_t;

	typedef struct packed {
		logic [2:0]      status;
		logic            fired;
		logic [ID_W-1:0] id;
		logic [7:0]      handler;
		logic [31:0]     arg;
		logic            last;
	} res_t;

	function automatic logic [ID_W-1:0] make_id(input logic [SLOT_W-1:0] slot,
		input logic [GEN_W-1:0] gen);
		logic [SLOT_W+GEN_W+3:0] w;
		w = '0;
		w[GEN_W +: SLOT_W] = slot;
		w[GEN_W-1:0] = gen;
		return w[ID_W-1:0];
	endfunction

endpackage

// ----- rtl/core/itt_ram.sv -----
`timescale 1ns / 1ps

module itt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/interval_timer_table_unit.sv -----
`timescale 1ns / 1ps
// Add, stop, clear and unknown items pass the decode state only; an add that links behind
// an existing tail then passes the link state, a stop or clear that reaches the generation
// check the check state. Tick and restart all walk the insertion list one live timer per
// cycle through the single read port of the record memory; an empty list skips the walk.
// A result is strobed by done the cycle after it is formed and cannot be stalled; the next
// item is accepted in the first cycle busy is low. Reset clears valid bits, list ends, count.

module interval_timer_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] now,
	input  logic [23:0] interval,
	input  logic [23:0] timer_id,
	input  logic [7:0]  handler,
	input  logic [31:0] argument,
	output logic        done,
	output logic [2:0]  status,
	output logic        fired,
	output logic [19:0] result_id,
	output logic [7:0]  out_handler,
	output logic [31:0] out_argument,
	output logic        last
);

	localparam int SW = itt_pkg::SLOT_W;
	localparam int LW = itt_pkg::LINK_W;
	localparam int RW = $bits(itt_pkg::rec_t);

	itt_pkg::state_t state_q, state_d;

	logic [2:0]  func_q;
	logic [31:0] now_q;
	logic [23:0] ivl_q;
	logic [23:0] tid_q;
	logic [7:0]  hnd_q;
	logic [31:0] arg_q;

	logic [itt_pkg::SLOTS-1:0] valid_q, valid_d;
	logic [LW-1:0] head_q, head_d, tail_q, tail_d, lnk_q, lnk_d;
	logic [itt_pkg::GEN_W-1:0] cnt_q, cnt_d;
	logic [SW-1:0] slot_q, slot_d;
	logic [itt_pkg::FIRE_W-1:0] nfire_q, nfire_d;
	itt_pkg::res_t pend_q, pend_d, out_q, res_d;
	logic pend_v_q, pend_v_d, out_v_q, emit;

	logic rec_we, nxt_we, prv_we;
	logic [SW-1:0] rec_wa, nxt_wa, prv_wa, rd_addr;
	itt_pkg::rec_t rec_wd, rec_rd;
	logic [RW-1:0] rec_rd_raw;
	logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

	logic [SW-1:0] free_slot;
	logic free_found;

	assign rec_rd = itt_pkg::rec_t'(rec_rd_raw);

	itt_ram #(.WIDTH(RW), .DEPTH(itt_pkg::SLOTS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
		.raddr(rd_addr), .rdata(rec_rd_raw)
	);

	itt_ram #(.WIDTH(LW), .DEPTH(itt_pkg::SLOTS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(rd_addr), .rdata(nxt_rd)
	);

	itt_ram #(.WIDTH(LW), .DEPTH(itt_pkg::SLOTS)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(rd_addr), .rdata(prv_rd)
	);

	always_comb begin
		free_slot = '0;
		free_found = 1'b0;
		for (int i = itt_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SW'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		if (state_q == itt_pkg::S_WALK) begin
			rd_addr = nxt_rd[SW-1:0];
		end else if (func_q == itt_pkg::FN_TICK || func_q == itt_pkg::FN_RSTALL) begin
			rd_addr = head_q[SW-1:0];
		end else begin
			rd_addr = tid_q[16 +: SW];
		end
	end

	always_comb begin
		state_d  = state_q;
		valid_d  = valid_q;
		head_d   = head_q;
		tail_d   = tail_q;
		lnk_d    = lnk_q;
		cnt_d    = cnt_q;
		slot_d   = slot_q;
		nfire_d  = nfire_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		emit     = 1'b0;
		res_d    = '0;
		rec_we   = 1'b0;
		rec_wa   = slot_q;
		rec_wd   = rec_rd;
		nxt_we   = 1'b0;
		nxt_wa   = '0;
		nxt_wd   = '0;
		prv_we   = 1'b0;
		prv_wa   = '0;
		prv_wd   = '0;

		case (state_q)
			itt_pkg::S_IDLE: begin
				if (start) begin
					state_d = itt_pkg::S_DECODE;
				end
			end

			itt_pkg::S_DECODE: begin
				state_d = itt_pkg::S_IDLE;
				res_d.last = 1'b1;
				case (func_q)
					itt_pkg::FN_ADD: begin
						emit = 1'b1;
						if (ivl_q == '0) begin
							res_d.status = itt_pkg::ST_BAD_IVL;
						end else if (!free_found) begin
							res_d.status = itt_pkg::ST_FULL;
						end else begin
							rec_we = 1'b1;
							rec_wa = free_slot;
							rec_wd.expiry  = now_q + 32'(ivl_q);
							rec_wd.period  = ivl_q;
							rec_wd.gen     = cnt_q;
							rec_wd.handler = hnd_q;
							rec_wd.arg     = arg_q;
							nxt_we = 1'b1;
							nxt_wa = free_slot;
							nxt_wd = itt_pkg::LINK_NONE;
							prv_we = 1'b1;
							prv_wa = free_slot;
							prv_wd = tail_q;
							valid_d[free_slot] = 1'b1;
							cnt_d  = cnt_q + 1'b1;
							tail_d = LW'(free_slot);
							slot_d = free_slot;
							lnk_d  = tail_q;
							if (tail_q == itt_pkg::LINK_NONE) begin
								head_d = LW'(free_slot);
							end else begin
								state_d = itt_pkg::S_ADD_LINK;
							end
							res_d.status = itt_pkg::ST_OK;
							res_d.id = itt_pkg::make_id(free_slot, cnt_q);
						end
					end
					itt_pkg::FN_STOP, itt_pkg::FN_CLEAR: begin
						if (tid_q[23:16] >= 8'(itt_pkg::SLOTS)) begin
							emit = 1'b1;
							res_d.status = itt_pkg::ST_RANGE;
						end else if (!valid_q[tid_q[16 +: SW]]) begin
							emit = 1'b1;
							res_d.status = itt_pkg::ST_MISMATCH;
						end else begin
							slot_d = tid_q[16 +: SW];
							state_d = itt_pkg::S_CHECK;
						end
					end
					itt_pkg::FN_TICK, itt_pkg::FN_RSTALL: begin
						nfire_d = '0;
						pend_v_d = 1'b0;
						if (head_q == itt_pkg::LINK_NONE) begin
							emit = 1'b1;
						end else begin
							slot_d = head_q[SW-1:0];
							state_d = itt_pkg::S_WALK;
						end
					end
					default: begin
						emit = 1'b1;
					end
				endcase
			end

			itt_pkg::S_ADD_LINK: begin
				nxt_we = 1'b1;
				nxt_wa = lnk_q[SW-1:0];
				nxt_wd = LW'(slot_q);
				state_d = itt_pkg::S_IDLE;
			end

			itt_pkg::S_CHECK: begin
				state_d = itt_pkg::S_IDLE;
				emit = 1'b1;
				res_d.last = 1'b1;
				if (rec_rd.gen != tid_q[15:0]) begin
					res_d.status = itt_pkg::ST_MISMATCH;
				end else begin
					res_d.status = itt_pkg::ST_OK;
					if (func_q == itt_pkg::FN_STOP) begin
						valid_d[slot_q] = 1'b0;
						if (prv_rd != itt_pkg::LINK_NONE) begin
							nxt_we = 1'b1;
							nxt_wa = prv_rd[SW-1:0];
							nxt_wd = nxt_rd;
						end else begin
							head_d = nxt_rd;
						end
						if (nxt_rd != itt_pkg::LINK_NONE) begin
							prv_we = 1'b1;
							prv_wa = nxt_rd[SW-1:0];
							prv_wd = prv_rd;
						end else begin
							tail_d = prv_rd;
						end
					end else begin
						rec_we = 1'b1;
						rec_wd.expiry = now_q + 32'(rec_rd.period);
					end
				end
			end

			itt_pkg::S_WALK: begin
				if (valid_q[slot_q]) begin
					if (func_q == itt_pkg::FN_RSTALL) begin
						rec_we = 1'b1;
						rec_wd.expiry = now_q + 32'(rec_rd.period);
					end else if (now_q > rec_rd.expiry &&
						nfire_q < itt_pkg::FIRE_W'(itt_pkg::MAX_OUT)) begin
						rec_we = 1'b1;
						rec_wd.expiry = now_q + 32'(rec_rd.period);
						nfire_d = nfire_q + 1'b1;
						if (pend_v_q) begin
							emit = 1'b1;
							res_d = pend_q;
						end
						pend_v_d = 1'b1;
						pend_d.status  = itt_pkg::ST_OK;
						pend_d.fired   = 1'b1;
						pend_d.id      = itt_pkg::make_id(slot_q, rec_rd.gen);
						pend_d.handler = rec_rd.handler;
						pend_d.arg     = rec_rd.arg;
						pend_d.last    = 1'b0;
					end
				end
				slot_d = nxt_rd[SW-1:0];
				if (nxt_rd == itt_pkg::LINK_NONE) begin
					state_d = itt_pkg::S_FINISH;
				end
			end

			itt_pkg::S_FINISH: begin
				state_d = itt_pkg::S_IDLE;
				emit = 1'b1;
				if (pend_v_q) begin
					res_d = pend_q;
				end
				res_d.last = 1'b1;
				pend_v_d = 1'b0;
			end

			default: begin
				state_d = itt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itt_pkg::S_IDLE;
			valid_q  <= '0;
			head_q   <= itt_pkg::LINK_NONE;
			tail_q   <= itt_pkg::LINK_NONE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			nfire_q  <= '0;
		end else begin
			state_q  <= state_d;
			valid_q  <= valid_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			out_v_q  <= emit;
			nfire_q  <= nfire_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itt_pkg::S_IDLE && start) begin
			func_q <= func;
			now_q  <= now;
			ivl_q  <= interval;
			tid_q  <= timer_id;
			hnd_q  <= handler;
			arg_q  <= argument;
		end
		slot_q <= slot_d;
		lnk_q  <= lnk_d;
		pend_q <= pend_d;
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign busy         = (state_q != itt_pkg::S_IDLE);
	assign done         = out_v_q;
	assign status       = out_q.status;
	assign fired        = out_q.fired;
	assign result_id    = out_q.id;
	assign out_handler  = out_q.handler;
	assign out_argument = out_q.arg;
	assign last         = out_q.last;

endmodule
